>>> rtl/vsd_pkg.sv
`timescale 1ns / 1ps
package vsd_pkg;

  localparam int unsigned DataW    = 32;
  localparam int unsigned ScaleW   = 40;
  localparam int unsigned CfgAddrW = 3;
  localparam int unsigned CfgDataW = 40;
  localparam int unsigned ItemW    = 3 * DataW;
  localparam int unsigned DiffW    = 35;
  localparam int unsigned TermW    = 60;
  localparam int unsigned SumW     = 63;
  localparam int unsigned MulAW    = 48;
  localparam int unsigned MulBW    = 40;
  localparam int unsigned MulPW    = MulAW + MulBW;

  // configuration register indexes
  localparam logic [CfgAddrW-1:0] CFG_VISC      = 3'd0;
  localparam logic [CfgAddrW-1:0] CFG_INV_DX_SQ = 3'd1;
  localparam logic [CfgAddrW-1:0] CFG_INV_DY_SQ = 3'd2;
  localparam logic [CfgAddrW-1:0] CFG_INV_DXDY  = 3'd3;
  localparam logic [CfgAddrW-1:0] CFG_PAD_W     = 3'd4;
  localparam logic [CfgAddrW-1:0] CFG_PAD_H     = 3'd5;

  // stencil term indexes, in evaluation order
  localparam logic [2:0] TRM_DXX_X   = 3'd0;
  localparam logic [2:0] TRM_DYY_X   = 3'd1;
  localparam logic [2:0] TRM_CROSS_X = 3'd2;
  localparam logic [2:0] TRM_DXX_Y   = 3'd3;
  localparam logic [2:0] TRM_DYY_Y   = 3'd4;
  localparam logic [2:0] TRM_CROSS_Y = 3'd5;
  localparam logic [2:0] TRM_DXX_Z   = 3'd6;
  localparam logic [2:0] TRM_DYY_Z   = 3'd7;
  localparam logic [2:0] TRM_LAST    = TRM_DYY_Z;
  localparam logic [2:0] FIN_LAST    = 3'd2;

  typedef struct packed {
    logic       take;
    logic       rd_mid;
    logic       wr;
    logic       term_start;
    logic       term_wait;
    logic       term_acc;
    logic       fin_start;
    logic       fin_wait;
    logic       out_load;
    logic [2:0] idx;
  } vsd_cmd_t;

  typedef struct packed {
    logic has_res;
    logic mul_done;
    logic out_busy;
  } vsd_sts_t;

endpackage

>>> rtl/vsd_mul.sv
`timescale 1ns / 1ps
module vsd_mul (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [vsd_pkg::MulAW-1:0] a_i,
  input  logic [vsd_pkg::MulBW-1:0] b_i,
  output logic                      done_o,
  output logic [vsd_pkg::MulPW-1:0] prod_o
);
  import vsd_pkg::*;

  localparam int unsigned AChW = MulAW / 2;
  localparam int unsigned BChW = MulBW / 2;
  localparam int unsigned PpW  = AChW + BChW;

  logic             busy_q, pv_q;
  logic [2:0]       step_q;
  logic [1:0]       sh_q;
  logic [MulAW-1:0] a_q;
  logic [MulBW-1:0] b_q;
  logic [PpW-1:0]   pp_q;
  logic [MulPW-1:0] acc_q;
  logic [AChW-1:0]  a_ch;
  logic [BChW-1:0]  b_ch;
  logic [MulPW-1:0] pp_sh;

  assign a_ch   = step_q[1] ? a_q[MulAW-1:AChW] : a_q[AChW-1:0];
  assign b_ch   = step_q[0] ? b_q[MulBW-1:BChW] : b_q[BChW-1:0];
  assign done_o = busy_q && (step_q == 3'd4) && !pv_q;
  assign prod_o = acc_q;

  // place the partial product at its chunk offset
  always_comb begin
    case (sh_q)
      2'd0:    pp_sh = MulPW'(pp_q);
      2'd1:    pp_sh = MulPW'(pp_q) << BChW;
      2'd2:    pp_sh = MulPW'(pp_q) << AChW;
      default: pp_sh = MulPW'(pp_q) << (AChW + BChW);
    endcase
  end

  // step control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      pv_q   <= 1'b0;
      step_q <= 3'd0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      pv_q   <= 1'b0;
      step_q <= 3'd0;
    end else if (busy_q) begin
      if (step_q != 3'd4) begin
        step_q <= step_q + 3'd1;
        pv_q   <= 1'b1;
      end else begin
        pv_q <= 1'b0;
      end
      if (done_o) begin
        busy_q <= 1'b0;
      end
    end
  end

  // one chunk product per cycle, accumulated the cycle after
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q   <= a_i;
      b_q   <= b_i;
      acc_q <= '0;
    end else if (busy_q) begin
      if (step_q != 3'd4) begin
        pp_q <= a_ch * b_ch;
        sh_q <= step_q[1:0];
      end
      if (pv_q) begin
        acc_q <= acc_q + pp_sh;
      end
    end
  end

endmodule

>>> rtl/vsd_datapath.sv
`timescale 1ns / 1ps
module vsd_datapath #(
  parameter int unsigned MAX_ROW_CELLS = 1024
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [vsd_pkg::CfgAddrW-1:0] cfg_addr_i,
  input  logic [vsd_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                         in_valid_i,
  input  logic [vsd_pkg::ItemW-1:0]    in_data_i,
  input  logic                         out_ready_i,
  output logic                         out_valid_o,
  output logic [vsd_pkg::ItemW-1:0]    out_data_o,
  output logic                         out_last_o,
  input  vsd_pkg::vsd_cmd_t            cmd_i,
  output vsd_pkg::vsd_sts_t            sts_o
);
  import vsd_pkg::*;

  localparam int unsigned CW    = $clog2(MAX_ROW_CELLS);
  localparam int unsigned AW    = CW + 1;
  localparam int unsigned Depth = 2 << CW;

  // configuration registers
  logic signed [DataW-1:0] visc_q;
  logic [ScaleW-1:0]       dx_q, dy_q, dxdy_q;
  logic [10:0]             pw_q;
  logic [15:0]             ph_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      visc_q <= '0;
      dx_q   <= ScaleW'(65536);
      dy_q   <= ScaleW'(65536);
      dxdy_q <= ScaleW'(65536);
      pw_q   <= 11'd1024;
      ph_q   <= 16'd1024;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        CFG_VISC:      visc_q <= cfg_data_i[DataW-1:0];
        CFG_INV_DX_SQ: dx_q   <= cfg_data_i;
        CFG_INV_DY_SQ: dy_q   <= cfg_data_i;
        CFG_INV_DXDY:  dxdy_q <= cfg_data_i;
        CFG_PAD_W:     pw_q   <= cfg_data_i[10:0];
        CFG_PAD_H:     ph_q   <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  // effective geometry
  logic [CW:0] w_eff;
  logic [15:0] h_eff;

  always_comb begin
    if ({21'd0, pw_q} > 32'(MAX_ROW_CELLS)) begin
      w_eff = (CW+1)'(MAX_ROW_CELLS);
    end else if (pw_q < 11'd3) begin
      w_eff = (CW+1)'(3);
    end else begin
      w_eff = (CW+1)'(pw_q);
    end
    h_eff = (ph_q < 16'd3) ? 16'd3 : ph_q;
  end

  // position counters
  logic [CW-1:0] col_q;
  logic [15:0]   row_q;
  logic          row_last, frame_last;

  assign row_last   = ({1'b0, col_q} + (CW+1)'(1)) >= w_eff;
  assign frame_last = row_last && (({1'b0, row_q} + 17'd1) >= {1'b0, h_eff});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (cmd_i.wr) begin
      if (row_last) begin
        col_q <= '0;
        row_q <= frame_last ? 16'd0 : row_q + 16'd1;
      end else begin
        col_q <= col_q + CW'(1);
      end
    end
  end

  // line buffers, x/y/z side by side in one word, two row banks
  logic [ItemW-1:0] mem [Depth];
  logic [ItemW-1:0] samp_q, rd_q, top_q;
  logic [AW-1:0]    addr_old, addr_mid;
  logic             take;

  assign take     = cmd_i.take && in_valid_i;
  assign addr_old = {row_q[0], col_q};
  assign addr_mid = {~row_q[0], col_q};

  always_ff @(posedge clk_i) begin
    if (take) begin
      rd_q   <= mem[addr_old];
      samp_q <= in_data_i;
    end else if (cmd_i.rd_mid) begin
      rd_q  <= mem[addr_mid];
      top_q <= rd_q;
    end
    if (cmd_i.wr) begin
      mem[addr_old] <= samp_q;
    end
  end

  // 3x3 window per component: [comp][row j-1..j+1][col i-1..i+1]
  logic signed [DataW-1:0] win_q [3][3][3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < 3; c++) begin
        for (int r = 0; r < 3; r++) begin
          for (int k = 0; k < 3; k++) begin
            win_q[c][r][k] <= '0;
          end
        end
      end
    end else if (cmd_i.wr) begin
      for (int c = 0; c < 3; c++) begin
        for (int r = 0; r < 3; r++) begin
          win_q[c][r][0] <= win_q[c][r][1];
          win_q[c][r][1] <= win_q[c][r][2];
        end
        win_q[c][0][2] <= top_q[c*DataW +: DataW];
        win_q[c][1][2] <= rd_q[c*DataW +: DataW];
        win_q[c][2][2] <= samp_q[c*DataW +: DataW];
      end
    end
  end

  function automatic logic signed [DiffW-1:0] sx(input logic signed [DataW-1:0] v);
    sx = {{(DiffW-DataW){v[DataW-1]}}, v};
  endfunction

  // difference and scale of the current term
  logic signed [DiffW-1:0] diff;
  logic [ScaleW-1:0]       scale;
  logic [DiffW-1:0]        diff_mag;

  always_comb begin
    case (cmd_i.idx)
      TRM_DXX_X, TRM_DXX_Y, TRM_DXX_Z: scale = dx_q;
      TRM_DYY_X, TRM_DYY_Y, TRM_DYY_Z: scale = dy_q;
      default:                         scale = dxdy_q;
    endcase
    case (cmd_i.idx)
      TRM_DXX_X: diff = sx(win_q[0][1][2]) - (sx(win_q[0][1][1]) <<< 1) + sx(win_q[0][1][0]);
      TRM_DYY_X: diff = sx(win_q[0][2][1]) - (sx(win_q[0][1][1]) <<< 1) + sx(win_q[0][0][1]);
      TRM_CROSS_X: diff = sx(win_q[1][1][2]) - sx(win_q[1][1][1])
                          - sx(win_q[1][0][2]) + sx(win_q[1][0][1]);
      TRM_DXX_Y: diff = sx(win_q[1][1][2]) - (sx(win_q[1][1][1]) <<< 1) + sx(win_q[1][1][0]);
      TRM_DYY_Y: diff = sx(win_q[1][2][1]) - (sx(win_q[1][1][1]) <<< 1) + sx(win_q[1][0][1]);
      TRM_CROSS_Y: diff = sx(win_q[0][2][1]) - sx(win_q[0][1][1])
                          - sx(win_q[0][2][0]) + sx(win_q[0][1][0]);
      TRM_DXX_Z: diff = sx(win_q[2][1][2]) - (sx(win_q[2][1][1]) <<< 1) + sx(win_q[2][1][0]);
      default:   diff = sx(win_q[2][2][1]) - (sx(win_q[2][1][1]) <<< 1) + sx(win_q[2][0][1]);
    endcase
    diff_mag = diff[DiffW-1] ? DiffW'(-diff) : DiffW'(diff);
  end

  // final product operands
  logic signed [SumW-1:0] sum_q [3];
  logic signed [SumW-1:0] sum_sel;
  logic [SumW-1:0]        sum_mag;
  logic [DataW-1:0]       visc_mag;
  logic                   sum_big;

  always_comb begin
    case (cmd_i.idx)
      3'd0:    sum_sel = sum_q[0];
      3'd1:    sum_sel = sum_q[1];
      default: sum_sel = sum_q[2];
    endcase
    sum_mag  = sum_sel[SumW-1] ? SumW'(-sum_sel) : SumW'(sum_sel);
    visc_mag = visc_q[DataW-1] ? DataW'(-visc_q) : DataW'(visc_q);
    sum_big  = (|sum_mag[SumW-1:MulAW]) && (visc_q != '0);
  end

  // shared multiplier
  logic             mul_start, mul_done;
  logic [MulAW-1:0] mul_a;
  logic [MulBW-1:0] mul_b;
  logic [MulPW-1:0] prod;
  logic [MulPW-1:0] prod_rnd;

  assign mul_start = cmd_i.term_start || cmd_i.fin_start;
  assign mul_a     = cmd_i.term_start ? MulAW'(diff_mag) : sum_mag[MulAW-1:0];
  assign mul_b     = cmd_i.term_start ? scale : MulBW'(visc_mag);
  assign prod_rnd  = prod + MulPW'(32'h8000);

  vsd_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .done_o  (mul_done),
    .prod_o  (prod)
  );

  // rounded term and final saturation
  logic                   neg_q, big_q, last_q;
  logic signed [TermW-1:0] term_q;
  logic [TermW-2:0]       term_mag;
  logic [MulPW-17:0]      fin_mag;
  logic [DataW-1:0]       fin_val;
  logic [DataW-1:0]       res_q [3];

  assign term_mag = prod_rnd[TermW+14:16];
  assign fin_mag  = prod_rnd[MulPW-1:16];

  always_comb begin
    if (neg_q) begin
      if (big_q || fin_mag > (MulPW-16)'(33'h80000000)) begin
        fin_val = 32'h80000000;
      end else begin
        fin_val = DataW'(-fin_mag[DataW-1:0]);
      end
    end else begin
      if (big_q || fin_mag > (MulPW-16)'(32'h7FFFFFFF)) begin
        fin_val = 32'h7FFFFFFF;
      end else begin
        fin_val = fin_mag[DataW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr) begin
      last_q <= frame_last;
    end
    if (cmd_i.term_start) begin
      neg_q <= diff[DiffW-1];
    end else if (cmd_i.fin_start) begin
      neg_q <= (sum_sel[SumW-1] == visc_q[DataW-1]);
      big_q <= sum_big;
    end
    if (cmd_i.term_wait && mul_done) begin
      term_q <= neg_q ? -$signed({1'b0, term_mag}) : $signed({1'b0, term_mag});
    end
    if (cmd_i.fin_wait && mul_done) begin
      case (cmd_i.idx)
        3'd0:    res_q[0] <= fin_val;
        3'd1:    res_q[1] <= fin_val;
        default: res_q[2] <= fin_val;
      endcase
    end
  end

  // weighted sums of the terms
  logic signed [SumW-1:0] term_ext;

  assign term_ext = SumW'(term_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr) begin
      for (int c = 0; c < 3; c++) begin
        sum_q[c] <= '0;
      end
    end else if (cmd_i.term_acc) begin
      case (cmd_i.idx)
        TRM_DXX_X:              sum_q[0] <= sum_q[0] + (term_ext <<< 1);
        TRM_DYY_X, TRM_CROSS_X: sum_q[0] <= sum_q[0] + term_ext;
        TRM_DYY_Y:              sum_q[1] <= sum_q[1] + (term_ext <<< 1);
        TRM_DXX_Y, TRM_CROSS_Y: sum_q[1] <= sum_q[1] + term_ext;
        default:                sum_q[2] <= sum_q[2] + term_ext;
      endcase
    end
  end

  // output register
  logic             out_valid_q;
  logic [ItemW-1:0] out_data_q;
  logic             out_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_data_q <= {res_q[2], res_q[1], res_q[0]};
      out_last_q <= last_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign out_data_o     = out_data_q;
  assign out_last_o     = out_last_q;
  assign sts_o.has_res  = (col_q >= CW'(2)) && (row_q >= 16'd2);
  assign sts_o.mul_done = mul_done;
  assign sts_o.out_busy = out_valid_q && !out_ready_i;

endmodule

>>> rtl/vsd_ctrl.sv
`timescale 1ns / 1ps
module vsd_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  vsd_pkg::vsd_sts_t  sts_i,
  output vsd_pkg::vsd_cmd_t  cmd_o
);
  import vsd_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE, ST_RD_MID, ST_WR, ST_T_START, ST_T_WAIT, ST_T_ACC,
    ST_F_START, ST_F_WAIT, ST_OUT
  } state_e;

  state_e     state_q;
  logic [2:0] idx_q;

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      idx_q   <= '0;
    end else begin
      unique case (state_q)
        ST_IDLE:    if (in_valid_i) state_q <= ST_RD_MID;
        ST_RD_MID:  state_q <= ST_WR;
        ST_WR: begin
          idx_q   <= '0;
          state_q <= sts_i.has_res ? ST_T_START : ST_IDLE;
        end
        ST_T_START: state_q <= ST_T_WAIT;
        ST_T_WAIT:  if (sts_i.mul_done) state_q <= ST_T_ACC;
        ST_T_ACC: begin
          if (idx_q == TRM_LAST) begin
            idx_q   <= '0;
            state_q <= ST_F_START;
          end else begin
            idx_q   <= idx_q + 3'd1;
            state_q <= ST_T_START;
          end
        end
        ST_F_START: state_q <= ST_F_WAIT;
        ST_F_WAIT: begin
          if (sts_i.mul_done) begin
            if (idx_q == FIN_LAST) begin
              state_q <= ST_OUT;
            end else begin
              idx_q   <= idx_q + 3'd1;
              state_q <= ST_F_START;
            end
          end
        end
        ST_OUT:     if (!sts_i.out_busy) state_q <= ST_IDLE;
        default:    state_q <= ST_IDLE;
      endcase
    end
  end

  // commands to the datapath
  assign in_ready_o       = (state_q == ST_IDLE);
  assign cmd_o.take       = (state_q == ST_IDLE);
  assign cmd_o.rd_mid     = (state_q == ST_RD_MID);
  assign cmd_o.wr         = (state_q == ST_WR);
  assign cmd_o.term_start = (state_q == ST_T_START);
  assign cmd_o.term_wait  = (state_q == ST_T_WAIT);
  assign cmd_o.term_acc   = (state_q == ST_T_ACC);
  assign cmd_o.fin_start  = (state_q == ST_F_START);
  assign cmd_o.fin_wait   = (state_q == ST_F_WAIT);
  assign cmd_o.out_load   = (state_q == ST_OUT) && !sts_i.out_busy;
  assign cmd_o.idx        = idx_q;

endmodule

>>> rtl/viscous_stress_divergence_stencil.sv
`timescale 1ns / 1ps
// Viscous stress divergence over a ghost-padded 2D velocity grid.
// Input stream: one padded cell per transaction in raster order, tdata holds
// vel_x, vel_y, vel_z (Q16.16). Output stream: one transaction per interior
// cell with div_x, div_y, div_z (Q16.16, saturated); tlast marks the last
// interior cell of the frame.
// Configuration: write cfg_we_i with cfg_addr_i = register index (viscosity,
// inv_dx_sq, inv_dy_sq, inv_dxdy, padded_width, padded_height) while idle.
// Sequence: a border cell passes only the line buffer access states. An
// interior cell then takes eight scaled differences and three viscosity
// products, passed one at a time through a shared multiplier that works in
// four 24x20 chunk products, and an output load. No new cell is accepted
// until the block returns to idle.
// The line buffer is read twice and written once per cell on its single port.
// The result sits in an output register; the next cell is accepted while it
// waits. A stalled receiver holds the block in its output state once the
// following result is ready.
// Reset clears counters, window and configuration registers to defaults; line buffer
// contents stay undefined until written by the first rows of a frame.
module viscous_stress_divergence_stencil #(
  parameter int unsigned MAX_ROW_CELLS = 1024
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [vsd_pkg::ItemW-1:0]    s_axis_tdata,  // vel_x, vel_y, vel_z
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  output logic [vsd_pkg::ItemW-1:0]    m_axis_tdata,  // div_x, div_y, div_z
  output logic                         m_axis_tlast,
  input  logic                         cfg_we_i,
  input  logic [vsd_pkg::CfgAddrW-1:0] cfg_addr_i,
  input  logic [vsd_pkg::CfgDataW-1:0] cfg_data_i
);
  import vsd_pkg::*;

  vsd_cmd_t cmd;
  vsd_sts_t sts;

  vsd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  vsd_datapath #(
    .MAX_ROW_CELLS (MAX_ROW_CELLS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (s_axis_tvalid),
    .in_data_i   (s_axis_tdata),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_data_o  (m_axis_tdata),
    .out_last_o  (m_axis_tlast),
    .cmd_i       (cmd),
    .sts_o       (sts)
  );

endmodule
